// File: rtl/u8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
// used by u8d_front, u8d_queue, u8d_back and utf8_stream_decoder
`default_nettype none

package u8d_pkg;

    localparam int CP_W        = 21;
    localparam int USED_W      = 3;
    localparam int PAYLOAD_W   = 18;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CP_W-1:0]   RPL_CHAR = 21'h00FFFD;
    localparam logic [USED_W-1:0] USED_ONE = 3'd1;

    // one job: some replacement results, then optionally one final result
    typedef struct packed {
        logic [1:0]        rpl_cnt;
        logic              has_final;
        logic [CP_W-1:0]   cp;
        logic [USED_W-1:0] used;
    } t_job;

endpackage

`default_nettype wire

// File: rtl/utf8_stream_decoder.sv
// utf-8 stream decoder top level: front, job queue and back
// depends on u8d_pkg, u8d_front, u8d_queue, u8d_back
//
//   channel   direction  handshake            payload
//   bytes     in         push / full          i_in_byte, i_end_of_text
//   results   out        pop / empty          o_code_point, o_bytes_used, o_run_last
//
// one byte is taken each cycle while the job queue has room; the front updates its
// sequence state in the same cycle.
// the back drains one result per cycle while its output is popped or empty, and a byte
// yields up to four results on a broken sequence; the queue absorbs these runs.
// a byte's first result passes the job queue and then the back's output register.
// synchronous active-low reset empties queue and output, closes any open sequence.
`default_nettype none

module utf8_stream_decoder #(
    parameter int QDEPTH = u8d_pkg::QUEUE_DEPTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [7:0]                   i_in_byte,
    input  wire logic                         i_end_of_text,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [u8d_pkg::CP_W-1:0]          o_code_point,
    output logic [u8d_pkg::USED_W-1:0]        o_bytes_used,
    output logic                              o_run_last
);

    u8d_pkg::t_job  w_wr_job, w_rd_job;
    logic           w_wr_valid;
    logic           w_q_empty;
    logic           w_q_pop;
    logic           w_accept;

    assign w_accept = push && !full;

    u8d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_job         (w_wr_job),
        .o_job_valid   (w_wr_valid)
    );

    u8d_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_valid),
        .i_wr_data (w_wr_job),
        .i_rd_en   (w_q_pop),
        .o_rd_data (w_rd_job),
        .o_full    (full),
        .o_empty   (w_q_empty)
    );

    u8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_rd_job),
        .i_job_empty  (w_q_empty),
        .o_job_pop    (w_q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_code_point (o_code_point),
        .o_bytes_used (o_bytes_used),
        .o_run_last   (o_run_last)
    );

    // a multi-byte result always closes its run
    a_multi_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_bytes_used != u8d_pkg::USED_ONE) |-> o_run_last)
        else $error("multi-byte result not last of its run");

    // results ahead of the last one in a run are replacements
    a_early_is_rpl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_run_last) |-> (o_code_point == u8d_pkg::RPL_CHAR
            && o_bytes_used == u8d_pkg::USED_ONE))
        else $error("non-final result is not a replacement");

    // reset leaves nothing to pop
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

endmodule

`default_nettype wire

// File: rtl/u8d_front.sv
// front part: takes bytes, tracks the open sequence, emits at most one job per byte
// depends on u8d_pkg
`default_nettype none

module u8d_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_end_of_text,
    output u8d_pkg::t_job      o_job,
    output logic               o_job_valid
);

    logic [7:0]                     r_lead, n_lead;
    logic [u8d_pkg::PAYLOAD_W-1:0]  r_payload, n_payload;
    logic [1:0]                     r_seen, n_seen;
    logic [1:0]                     r_need, n_need;

    logic [1:0]                     seen_inc;
    logic [u8d_pkg::PAYLOAD_W-1:0]  pl_next;
    logic [u8d_pkg::CP_W-1:0]       cp_full;
    logic [1:0]                     fresh_need;
    logic                           is_cont;
    logic                           do_fresh;

    always_comb begin
        is_cont  = (i_in_byte[7:6] == 2'b10);
        seen_inc = r_seen + 2'd1;
        pl_next  = {r_payload[u8d_pkg::PAYLOAD_W-7:0], i_in_byte[5:0]};
        case (seen_inc)
            2'd1:    cp_full = {10'd0, r_lead[4:0], pl_next[5:0]};
            2'd2:    cp_full = {5'd0, r_lead[3:0], pl_next[11:0]};
            default: cp_full = {r_lead[2:0], pl_next};
        endcase
        case (i_in_byte[7:3]) inside
            [5'b11000:5'b11011]: fresh_need = 2'd1;
            [5'b11100:5'b11101]: fresh_need = 2'd2;
            5'b11110:            fresh_need = 2'd3;
            default:             fresh_need = 2'd0;
        endcase
    end

    always_comb begin
        n_lead    = r_lead;
        n_payload = r_payload;
        n_seen    = r_seen;
        n_need    = r_need;
        o_job     = '0;
        do_fresh  = 1'b0;
        if (r_need != 2'd0) begin
            if (is_cont) begin
                if (seen_inc == r_need) begin
                    o_job.has_final = 1'b1;
                    o_job.cp        = cp_full;
                    o_job.used      = {1'b0, seen_inc} + 3'd1;
                    n_lead = '0; n_payload = '0; n_seen = '0; n_need = '0;
                end else if (i_end_of_text) begin
                    // lead, buffered bytes and this byte all become replacements
                    o_job.rpl_cnt   = seen_inc;
                    o_job.has_final = 1'b1;
                    o_job.cp        = u8d_pkg::RPL_CHAR;
                    o_job.used      = u8d_pkg::USED_ONE;
                    n_lead = '0; n_payload = '0; n_seen = '0; n_need = '0;
                end else begin
                    n_seen    = seen_inc;
                    n_payload = pl_next;
                end
            end else begin
                // broken sequence: flush lead and buffered bytes, then restart
                o_job.rpl_cnt = seen_inc;
                n_lead = '0; n_payload = '0; n_seen = '0; n_need = '0;
                do_fresh = 1'b1;
            end
        end else begin
            do_fresh = 1'b1;
        end

        if (do_fresh) begin
            if (i_in_byte[7] == 1'b0) begin
                o_job.has_final = 1'b1;
                o_job.cp        = {13'd0, i_in_byte};
                o_job.used      = u8d_pkg::USED_ONE;
            end else if (fresh_need == 2'd0 || i_end_of_text) begin
                o_job.has_final = 1'b1;
                o_job.cp        = u8d_pkg::RPL_CHAR;
                o_job.used      = u8d_pkg::USED_ONE;
            end else begin
                n_lead    = i_in_byte;
                n_payload = '0;
                n_seen    = '0;
                n_need    = fresh_need;
            end
        end
        o_job_valid = i_accept && (o_job.has_final || o_job.rpl_cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead    <= '0;
            r_payload <= '0;
            r_seen    <= '0;
            r_need    <= '0;
        end else if (i_accept) begin
            r_lead    <= n_lead;
            r_payload <= n_payload;
            r_seen    <= n_seen;
            r_need    <= n_need;
        end
    end

endmodule

`default_nettype wire

// File: rtl/u8d_queue.sv
// small job queue between front and back, show-ahead read
// depends on u8d_pkg
`default_nettype none

module u8d_queue #(
    parameter int DEPTH = u8d_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire u8d_pkg::t_job i_wr_data,
    input  wire logic          i_rd_en,
    output u8d_pkg::t_job      o_rd_data,
    output logic               o_full,
    output logic               o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u8d_pkg::t_job     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_wr, do_rd;

    assign o_full    = (r_cnt == FULL_CNT);
    assign o_empty   = (r_cnt == '0);
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/u8d_back.sv
// back part: expands each job into results, one per cycle while the output is popped or empty, into an output register
// depends on u8d_pkg
`default_nettype none

module u8d_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire u8d_pkg::t_job                i_job,
    input  wire logic                         i_job_empty,
    output logic                              o_job_pop,
    input  wire logic                         i_pop,
    output logic                              o_empty,
    output logic [u8d_pkg::CP_W-1:0]          o_code_point,
    output logic [u8d_pkg::USED_W-1:0]        o_bytes_used,
    output logic                              o_run_last
);

    logic [1:0]                   r_idx;
    logic                         r_valid;
    logic [u8d_pkg::CP_W-1:0]     r_cp;
    logic [u8d_pkg::USED_W-1:0]   r_used;
    logic                         r_last;

    logic [2:0]                   total;
    logic                         emit;
    logic                         is_last;
    logic                         in_rpl;

    always_comb begin
        total   = {1'b0, i_job.rpl_cnt} + {2'b00, i_job.has_final};
        emit    = !i_job_empty && (!r_valid || i_pop);
        is_last = ({1'b0, r_idx} + 3'd1) == total;
        in_rpl  = r_idx < i_job.rpl_cnt;
    end

    assign o_job_pop    = emit && is_last;
    assign o_empty      = !r_valid;
    assign o_code_point = r_cp;
    assign o_bytes_used = r_used;
    assign o_run_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_cp   <= in_rpl ? u8d_pkg::RPL_CHAR : i_job.cp;
            r_used <= in_rpl ? u8d_pkg::USED_ONE : i_job.used;
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: bench/utf8_stream_decoder_test.sv
// self-checking testbench for utf8_stream_decoder: directed and random byte streams
// predicts each code point and compares every popped result in order
// depends on u8d_pkg and utf8_stream_decoder
`timescale 1ns / 1ps

module utf8_stream_decoder_test;

    localparam logic [u8d_pkg::CP_W-1:0] REPLACEMENT = 21'h00FFFD;
    localparam int LIMIT_CYCLES = 100000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic [u8d_pkg::CP_W-1:0]   cp;
        logic [u8d_pkg::USED_W-1:0] used;
        logic                       run_last;
    } t_code_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         push = 1'b0;
    logic [7:0]                   i_in_byte = 8'h00;
    logic                         i_end_of_text = 1'b0;
    logic                         pop = 1'b0;
    logic                         full;
    logic                         empty;
    logic [u8d_pkg::CP_W-1:0]     o_code_point;
    logic [u8d_pkg::USED_W-1:0]   o_bytes_used;
    logic                         o_run_last;

    // decoder state as the predictor sees it
    logic [7:0]  seq_lead = 8'h00;
    logic [17:0] seq_payload = 18'h0;
    logic [1:0]  seq_seen = 2'd0;
    logic [1:0]  seq_needed = 2'd0;

    t_code_result expected_codes[$];
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  bytes_sent = 0;
    int  step_results;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_active = 1'b0;
    int  pop_stall = 0;

    utf8_stream_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .empty         (empty),
        .pop           (pop),
        .o_code_point  (o_code_point),
        .o_bytes_used  (o_bytes_used),
        .o_run_last    (o_run_last)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // ---------------- predictor ----------------

    task automatic emit_code(input logic [u8d_pkg::CP_W-1:0] cp,
                             input logic [u8d_pkg::USED_W-1:0] used);
        t_code_result r;
        r.cp = cp;
        r.used = used;
        r.run_last = 1'b0;
        expected_codes.insert(expected_codes.size(), r);
        step_results++;
    endtask

    task automatic close_sequence();
        seq_lead = 8'h00;
        seq_payload = 18'h0;
        seq_seen = 2'd0;
        seq_needed = 2'd0;
    endtask

    // replacement for the lead, each buffered continuation and any extra bytes
    task automatic flush_broken_sequence(input int extra);
        int total;
        total = 1 + seq_seen + extra;
        repeat (total) emit_code(REPLACEMENT, 3'd1);
        close_sequence();
    endtask

    task automatic start_fresh_byte(input logic [7:0] b, input logic eot);
        logic [1:0] need;
        need = 2'd0;
        if (b[7] == 1'b0) begin
            emit_code({13'd0, b}, 3'd1);
        end else begin
            if (b[7:5] == 3'b110)
                need = 2'd1;
            else if (b[7:4] == 4'b1110)
                need = 2'd2;
            else if (b[7:3] == 5'b11110)
                need = 2'd3;
            if (need == 2'd0 || eot) begin
                emit_code(REPLACEMENT, 3'd1);
            end else begin
                seq_lead = b;
                seq_payload = 18'h0;
                seq_seen = 2'd0;
                seq_needed = need;
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic eot);
        int seen_next;
        logic [u8d_pkg::CP_W-1:0] cp;
        step_results = 0;
        if (seq_needed != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                seen_next = seq_seen + 1;
                seq_payload = {seq_payload[11:0], b[5:0]};
                if (seen_next == seq_needed) begin
                    case (seen_next)
                        1: cp = ({16'd0, seq_lead[4:0]} << 6) | {3'd0, seq_payload};
                        2: cp = ({17'd0, seq_lead[3:0]} << 12) | {3'd0, seq_payload};
                        default: cp = ({18'd0, seq_lead[2:0]} << 18) | {3'd0, seq_payload};
                    endcase
                    emit_code(cp, 3'(seen_next + 1));
                    close_sequence();
                end else if (eot) begin
                    flush_broken_sequence(1);
                end else begin
                    seq_seen = 2'(seen_next);
                end
            end else begin
                flush_broken_sequence(0);
                start_fresh_byte(b, eot);
            end
        end else begin
            start_fresh_byte(b, eot);
        end
        if (step_results > 0)
            expected_codes[expected_codes.size() - 1].run_last = 1'b1;
    endtask

    // ---------------- sender ----------------

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_in_byte <= b;
        i_end_of_text <= eot;
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
        end
        predict_byte(b, eot);
        bytes_sent++;
    endtask

    // ---------------- receiver and checker ----------------

    initial begin : receiver_hold
        wait (hold_req);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_active) begin
            pop <= 1'b0;
        end else if (pop_stall > 0) begin
            pop <= 1'b0;
            pop_stall <= pop_stall - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            pop <= 1'b0;
            pop_stall <= $urandom_range(0, 15);
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_code_result want;
        if (i_rst_n && pop && !empty) begin
            if (expected_codes.size() == 0) begin
                report_mismatch($sformatf("unexpected result cp=%h used=%0d last=%0b",
                    o_code_point, o_bytes_used, o_run_last));
            end else begin
                want = expected_codes.pop_front();
                if (o_code_point !== want.cp || o_bytes_used !== want.used
                        || o_run_last !== want.run_last)
                    report_mismatch($sformatf(
                        "expected cp=%h used=%0d last=%0b, got cp=%h used=%0d last=%0b",
                        want.cp, want.used, want.run_last,
                        o_code_point, o_bytes_used, o_run_last));
            end
        end
    end

    // ---------------- tests ----------------

    function automatic logic pick_eot();
        return ($urandom_range(0, 15) == 0);
    endfunction

    task automatic test_ascii();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_valid_sequences();
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    task automatic test_invalid_leads();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_broken_sequences();
        // lead and one continuation buffered, then ascii
        send_byte(8'hE1, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
        // lead cut off by another lead, which then ends early
        send_byte(8'hC3, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b1);
    endtask

    task automatic test_early_end();
        send_byte(8'hE2, 1'b1);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (6) begin
            send_byte(8'hF0, 1'b0);
            send_byte(8'h80, 1'b0);
            send_byte(8'h80, 1'b0);
            send_byte(8'h41, 1'b0);
        end
    endtask

    task automatic send_random_char();
        int kind;
        int need;
        int stop;
        logic [7:0] lead;
        kind = $urandom_range(0, 9);
        need = $urandom_range(1, 3);
        case (need)
            1: lead = 8'hC0 | 8'($urandom_range(0, 31));
            2: lead = 8'hE0 | 8'($urandom_range(0, 15));
            default: lead = 8'hF0 | 8'($urandom_range(0, 7));
        endcase
        if (kind <= 3) begin
            send_byte(8'($urandom_range(0, 127)), pick_eot());
        end else if (kind <= 7) begin
            send_byte(lead, 1'b0);
            for (int k = 0; k < need; k++)
                send_byte(8'h80 | 8'($urandom_range(0, 63)),
                          (k == need - 1) ? pick_eot() : 1'b0);
        end else if (kind == 8) begin
            send_byte(8'($urandom_range(0, 255)), pick_eot());
        end else begin
            // sequence that may be cut short, by a stray byte or by the end of the text
            stop = $urandom_range(0, need - 1);
            send_byte(lead, pick_eot());
            for (int k = 0; k < stop; k++)
                send_byte(8'h80 | 8'($urandom_range(0, 63)), pick_eot());
            send_byte(8'($urandom_range(0, 255)), pick_eot());
        end
    endtask

    task automatic test_random_stream(input int count);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < count)
            send_random_char();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        close_sequence();

        test_ascii();
        test_valid_sequences();
        test_invalid_leads();
        test_broken_sequences();
        test_early_end();
        test_backpressure();
        test_random_stream(40);
        quiet = 1'b1;
        test_random_stream(20);

        @(negedge i_clk);
        push <= 1'b0;
        while (expected_codes.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_codes.size() > 0)
            report_mismatch($sformatf("%0d results never arrived", expected_codes.size()));

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
